// ===== sv/four_op_register_memory_machine_unit_macros.svh =====
// ----------------------------------------------------------------------------
// four_op_register_memory_machine_unit_macros.svh
// Assertion shorthands shared by the RTL. Users must have clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef FOUR_OP_REGISTER_MEMORY_MACHINE_UNIT_MACROS_SVH
`define FOUR_OP_REGISTER_MEMORY_MACHINE_UNIT_MACROS_SVH

// Same-cycle implication.
`define FOMRM_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FOMRM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fomrm_pkg.sv =====
// ----------------------------------------------------------------------------
// fomrm_pkg
// Shared opcodes, status codes, field widths and the register write bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package fomrm_pkg;

    localparam int INSN_W     = 40;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 7;   // register index field in the word
    localparam int OFF_W      = 14;
    localparam int IMM_W      = 25;  // absolute address, widest immediate
    localparam int KONST_W    = 24;
    localparam int SUM_W      = 33;  // base + offset, never wraps
    localparam int OUT_IDX_W  = 5;
    localparam int OUT_ADDR_W = 10;
    localparam int STATUS_W   = 2;
    localparam int OP_W       = 3;

    localparam logic [OP_W-1:0] OP_LDI = 3'd0;  // load constant
    localparam logic [OP_W-1:0] OP_ST  = 3'd1;  // store reg at base + off
    localparam logic [OP_W-1:0] OP_OR  = 3'd3;  // reg |= mem[base + off]
    localparam logic [OP_W-1:0] OP_LD  = 3'd7;  // load absolute address

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SKIP  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADOP = 2'd2;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

endpackage

`default_nettype wire

// ===== sv/fomrm_ram.sv =====
// ----------------------------------------------------------------------------
// fomrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fomrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/fomrm_regs.sv =====
// ----------------------------------------------------------------------------
// fomrm_regs
// Register file: two read copies, per-entry valid bits for reset-to-zero,
// bypass from the pending write and from the last committed write.
// ----------------------------------------------------------------------------
`default_nettype none

module fomrm_regs #(
    parameter int REG_COUNT = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rd_en,
    input  logic [fomrm_pkg::IDX_W-1:0]      ra_idx,
    input  logic [fomrm_pkg::IDX_W-1:0]      rb_idx,
    input  fomrm_pkg::rf_wr_t                wr,      // pending write, oldest in flight
    input  logic                             commit,  // pending write retires this edge
    output logic [fomrm_pkg::DATA_W-1:0]     ra_data,
    output logic [fomrm_pkg::DATA_W-1:0]     rb_data
);

    localparam int RW = $clog2(REG_COUNT);

    logic [fomrm_pkg::IDX_W-1:0]  ra_q_reg;
    logic [fomrm_pkg::IDX_W-1:0]  rb_q_reg;
    logic [REG_COUNT-1:0]         vld_reg;
    logic                         lw_valid_reg;
    logic [fomrm_pkg::IDX_W-1:0]  lw_idx_reg;
    logic [fomrm_pkg::DATA_W-1:0] lw_data_reg;
    logic [fomrm_pkg::DATA_W-1:0] ram_a;
    logic [fomrm_pkg::DATA_W-1:0] ram_b;
    logic                         we;

    assign we = wr.en && commit;

    fomrm_ram #(
        .WIDTH (fomrm_pkg::DATA_W),
        .DEPTH (REG_COUNT)
    ) u_ram_a (
        .clk   (clk),
        .we    (we),
        .waddr (wr.idx[RW-1:0]),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (ra_idx[RW-1:0]),
        .rdata (ram_a)
    );

    fomrm_ram #(
        .WIDTH (fomrm_pkg::DATA_W),
        .DEPTH (REG_COUNT)
    ) u_ram_b (
        .clk   (clk),
        .we    (we),
        .waddr (wr.idx[RW-1:0]),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rb_idx[RW-1:0]),
        .rdata (ram_b)
    );

    // pending write > last committed write > never written (zero) > RAM
    function automatic logic [fomrm_pkg::DATA_W-1:0] pick(
        input logic [fomrm_pkg::IDX_W-1:0]  idx,
        input logic                         vld,
        input logic [fomrm_pkg::DATA_W-1:0] ram,
        input fomrm_pkg::rf_wr_t            pend,
        input logic                         lw_v,
        input logic [fomrm_pkg::IDX_W-1:0]  lw_i,
        input logic [fomrm_pkg::DATA_W-1:0] lw_d
    );
        priority if (pend.en && pend.idx == idx)
        begin
            return pend.data;
        end
        else if (lw_v && lw_i == idx)
        begin
            return lw_d;
        end
        else if (!vld)
        begin
            return '0;
        end
        else
        begin
            return ram;
        end
    endfunction

    assign ra_data = pick(ra_q_reg, vld_reg[ra_q_reg[RW-1:0]], ram_a, wr,
                          lw_valid_reg, lw_idx_reg, lw_data_reg);
    assign rb_data = pick(rb_q_reg, vld_reg[rb_q_reg[RW-1:0]], ram_b, wr,
                          lw_valid_reg, lw_idx_reg, lw_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            lw_valid_reg <= 1'b0;
        end
        else if (we)
        begin
            vld_reg[wr.idx[RW-1:0]] <= 1'b1;
            lw_valid_reg            <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ra_q_reg <= ra_idx;
            rb_q_reg <= rb_idx;
        end
        if (we)
        begin
            lw_idx_reg  <= wr.idx;
            lw_data_reg <= wr.data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fomrm_dmem.sv =====
// ----------------------------------------------------------------------------
// fomrm_dmem
// Data memory with a zero-fill sweep after reset, one word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fomrm_dmem #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          busy,
    input  logic                          we,
    input  logic [$clog2(MEM_DEPTH)-1:0]  waddr,
    input  logic [fomrm_pkg::DATA_W-1:0]  wdata,
    input  logic                          re,
    input  logic [$clog2(MEM_DEPTH)-1:0]  raddr,
    output logic [fomrm_pkg::DATA_W-1:0]  rdata
);

    localparam int AW = $clog2(MEM_DEPTH);

    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [fomrm_pkg::DATA_W-1:0] ram_wdata;

    assign busy      = clr_busy_reg;
    assign ram_we    = clr_busy_reg || we;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : waddr;
    assign ram_wdata = clr_busy_reg ? '0 : wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(MEM_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    fomrm_ram #(
        .WIDTH (fomrm_pkg::DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

endmodule

`default_nettype wire

// ===== sv/four_op_register_memory_machine_unit.sv =====
// ----------------------------------------------------------------------------
// four_op_register_memory_machine_unit
// Executes one instruction word per accepted input and returns one status
// word per instruction: what was written to a register or memory, if any.
//   Input channel : in_valid / in_ready, payload instruction_word (40 bits).
//   Output channel: out_valid / out_ready, payload status, reg_written,
//                   reg_index, reg_value, mem_written, mem_address, mem_value.
//   Stages: register read, memory read/store, write back into the output
//   register, which drives out_valid.
//   Throughput: one word per cycle unless stalled, back to back, including
//   dependent ones; the register file forwards from the two youngest writes.
//   Reset: register file reads as zero at once (valid bits); the data memory
//   is zero-filled by a sweep over all MEM_DEPTH words, in_ready stays low
//   until it finishes.
//   Stall: each stage holds while the one after it is full; a result waiting
//   in the output register still lets the pipe behind it fill up.
// ----------------------------------------------------------------------------
`default_nettype none
`include "four_op_register_memory_machine_unit_macros.svh"

module four_op_register_memory_machine_unit #(
    parameter int MEM_DEPTH = 1024,
    parameter int REG_COUNT = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [fomrm_pkg::INSN_W-1:0]         instruction_word,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [fomrm_pkg::STATUS_W-1:0]       status,
    output logic                                 reg_written,
    output logic [fomrm_pkg::OUT_IDX_W-1:0]      reg_index,
    output logic [fomrm_pkg::DATA_W-1:0]         reg_value,
    output logic                                 mem_written,
    output logic [fomrm_pkg::OUT_ADDR_W-1:0]     mem_address,
    output logic [fomrm_pkg::DATA_W-1:0]         mem_value
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [fomrm_pkg::IDX_W:0]   REG_LIMIT = (fomrm_pkg::IDX_W + 1)'(REG_COUNT);
    localparam logic [fomrm_pkg::SUM_W-1:0] MEM_LIMIT = fomrm_pkg::SUM_W'(MEM_DEPTH);

    // decoded word, held in stage 1
    typedef struct packed {
        logic [fomrm_pkg::OP_W-1:0]  op;
        logic [fomrm_pkg::IDX_W-1:0] dst;
        logic [fomrm_pkg::IDX_W-1:0] ra;   // store source, or OR destination
        logic [fomrm_pkg::IDX_W-1:0] rb;   // base register
        logic [fomrm_pkg::OFF_W-1:0] off;
        logic [fomrm_pkg::IMM_W-1:0] imm;  // constant or absolute address
        logic                        idx_ok;
    } dec_t;

    // stage 2: memory data arrives here
    typedef struct packed {
        logic [fomrm_pkg::STATUS_W-1:0]   status;
        logic                             rwr;
        logic                             store;
        logic [fomrm_pkg::OP_W-1:0]       op;
        logic [fomrm_pkg::IDX_W-1:0]      dst;
        logic [fomrm_pkg::DATA_W-1:0]     a_val;
        logic [fomrm_pkg::KONST_W-1:0]    konst;
        logic [fomrm_pkg::OUT_ADDR_W-1:0] maddr;
    } s2_t;

    typedef struct packed {
        logic [fomrm_pkg::STATUS_W-1:0]   status;
        logic                             rwr;
        logic [fomrm_pkg::OUT_IDX_W-1:0]  ridx;
        logic [fomrm_pkg::DATA_W-1:0]     rval;
        logic                             mwr;
        logic [fomrm_pkg::OUT_ADDR_W-1:0] maddr;
        logic [fomrm_pkg::DATA_W-1:0]     mval;
    } out_t;

    function automatic logic in_range(input logic [fomrm_pkg::IDX_W-1:0] idx);
        return {1'b0, idx} < REG_LIMIT;
    endfunction

    // ---------------------------------------------------------------- flow
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free, s2_open, s1_open, accept, dm_busy;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_open  = !s2_valid_reg || out_free;
    assign s1_open  = !s1_valid_reg || s2_open;
    assign in_ready = s1_open && !dm_busy;
    assign accept   = in_valid && in_ready;

    // ---------------------------------------------------------------- decode
    dec_t dec;
    logic [fomrm_pkg::INSN_W-1:0] w;

    assign w = instruction_word;

    always_comb
    begin
        dec        = '0;
        dec.op     = w[2:0];
        unique case (w[2:0])
            fomrm_pkg::OP_LDI:
            begin
                dec.dst    = w[33:27];
                dec.imm    = {1'b0, w[26:3]};
                dec.idx_ok = in_range(w[33:27]);
            end
            fomrm_pkg::OP_LD:
            begin
                dec.dst    = w[9:3];
                dec.imm    = w[34:10];
                dec.idx_ok = in_range(w[9:3]);
            end
            fomrm_pkg::OP_ST:
            begin
                dec.ra     = w[9:3];
                dec.rb     = w[16:10];
                dec.off    = w[30:17];
                dec.idx_ok = in_range(w[9:3]) && in_range(w[16:10]);
            end
            fomrm_pkg::OP_OR:
            begin
                dec.off    = w[16:3];
                dec.dst    = w[23:17];
                dec.ra     = w[23:17];
                dec.rb     = w[30:24];
                dec.idx_ok = in_range(w[23:17]) && in_range(w[30:24]);
            end
            default:
            begin
                dec.idx_ok = 1'b1;   // unknown opcode, status says so
            end
        endcase
    end

    // ---------------------------------------------------------------- stage 1
    dec_t s1_reg;
    s2_t  s2_reg, s2_next;
    fomrm_pkg::rf_wr_t s2_wr;
    logic [fomrm_pkg::DATA_W-1:0] ra_data, rb_data, mem_rdata, s2_value;
    logic [fomrm_pkg::SUM_W-1:0]  s1_addr;
    logic s1_known, s1_exec, s1_store;

    fomrm_regs #(
        .REG_COUNT (REG_COUNT)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .ra_idx  (dec.ra),
        .rb_idx  (dec.rb),
        .wr      (s2_wr),
        .commit  (out_free),
        .ra_data (ra_data),
        .rb_data (rb_data)
    );

    assign s1_known = s1_reg.op == fomrm_pkg::OP_LDI || s1_reg.op == fomrm_pkg::OP_ST ||
                      s1_reg.op == fomrm_pkg::OP_OR  || s1_reg.op == fomrm_pkg::OP_LD;

    // absolute address for loads, base + offset otherwise
    assign s1_addr  = (s1_reg.op == fomrm_pkg::OP_LD)
                    ? fomrm_pkg::SUM_W'(s1_reg.imm)
                    : {1'b0, rb_data} + fomrm_pkg::SUM_W'(s1_reg.off);

    assign s1_exec  = s1_known && s1_reg.idx_ok &&
                      (s1_reg.op == fomrm_pkg::OP_LDI || s1_addr < MEM_LIMIT);
    assign s1_store = s1_exec && s1_reg.op == fomrm_pkg::OP_ST;

    always_comb
    begin
        s2_next        = '0;
        s2_next.status = !s1_known ? fomrm_pkg::STATUS_BADOP
                       : s1_exec   ? fomrm_pkg::STATUS_OK
                       :             fomrm_pkg::STATUS_SKIP;
        s2_next.rwr    = s1_exec && s1_reg.op != fomrm_pkg::OP_ST;
        s2_next.store  = s1_store;
        s2_next.op     = s1_reg.op;
        s2_next.dst    = s1_reg.dst;
        s2_next.a_val  = ra_data;
        s2_next.konst  = s1_reg.imm[fomrm_pkg::KONST_W-1:0];
        s2_next.maddr  = s1_addr[fomrm_pkg::OUT_ADDR_W-1:0];
    end

    fomrm_dmem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (dm_busy),
        .we    (s1_valid_reg && s2_open && s1_store),
        .waddr (s1_addr[AW-1:0]),
        .wdata (ra_data),
        .re    (s2_open),
        .raddr (s1_addr[AW-1:0]),
        .rdata (mem_rdata)
    );

    // ---------------------------------------------------------------- stage 2
    always_comb
    begin
        unique case (s2_reg.op)
            fomrm_pkg::OP_LDI: s2_value = fomrm_pkg::DATA_W'(s2_reg.konst);
            fomrm_pkg::OP_LD:  s2_value = mem_rdata;
            default:           s2_value = s2_reg.a_val | mem_rdata;
        endcase
    end

    assign s2_wr.en   = s2_valid_reg && s2_reg.rwr;
    assign s2_wr.idx  = s2_reg.dst;
    assign s2_wr.data = s2_value;

    out_t out_reg, out_next;

    always_comb
    begin
        out_next        = '0;
        out_next.status = s2_reg.status;
        out_next.rwr    = s2_reg.rwr;
        out_next.mwr    = s2_reg.store;
        if (s2_reg.rwr)
        begin
            out_next.ridx = s2_reg.dst[fomrm_pkg::OUT_IDX_W-1:0];
            out_next.rval = s2_value;
        end
        if (s2_reg.store)
        begin
            out_next.maddr = s2_reg.maddr;
            out_next.mval  = s2_reg.a_val;
        end
    end

    // ---------------------------------------------------------------- registers
    assign s1_valid_next  = s1_open ? accept : s1_valid_reg;
    assign s2_valid_next  = s2_open ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = out_free ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= dec;
        end
        if (s2_open)
        begin
            s2_reg <= s2_next;
        end
        if (out_free)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign reg_written = out_reg.rwr;
    assign reg_index   = out_reg.ridx;
    assign reg_value   = out_reg.rval;
    assign mem_written = out_reg.mwr;
    assign mem_address = out_reg.maddr;
    assign mem_value   = out_reg.mval;

    // ---------------------------------------------------------------- checks
    `FOMRM_ASSERT_IMPL(a_pipe_empty_in_clear, dm_busy, !s1_valid_reg && !s2_valid_reg, "word in pipe during memory clear")
    `FOMRM_ASSERT_IMPL(a_single_target, out_valid_reg, !(out_reg.rwr && out_reg.mwr), "register and memory both written")
    `FOMRM_ASSERT_IMPL(a_skip_no_write, out_valid_reg && out_reg.status != fomrm_pkg::STATUS_OK, !out_reg.rwr && !out_reg.mwr, "skipped word reports a write")
    `FOMRM_ASSERT_NEXT(a_s2_kept, s2_valid_reg && !out_free, s2_valid_reg, "stage 2 word lost while stalled")

endmodule

`default_nettype wire
